/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/palt_pkg.sv */
package palt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 104;
	localparam int STEP_SHIFT    = 10;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CLAMP_W       = IDX_W + STEP_SHIFT;

	// field widths
	localparam int PRESS_W = 17;
	localparam int ALT_W   = 26;
	localparam int PROD_W  = ALT_W + STEP_SHIFT;

	// valid pressure window of the table
	localparam int P_MIN = 1 << STEP_SHIFT;
	localparam int P_MAX = (TABLE_ENTRIES << STEP_SHIFT) - 1;

	localparam int GROUND_RESET = 101325;

	// output buffer
	localparam int OBUF_DEPTH = 8;
	localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
	localparam int CNT_W      = OBUF_AW + 1;

	// stream widths, padded to whole bytes
	localparam int IN_TDATA_W  = ((PRESS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * ALT_W + 7) / 8) * 8;

	// altitude in mm at pressure (i+1) << STEP_SHIFT
	localparam int ALT_TABLE [TABLE_ENTRIES] = '{
		30898900, 26327697, 23696402, 21848320, 20425517, 19270467, 18292701,
		17445721, 16698633, 16030339, 15425794, 14873887, 14366183, 13896121,
		13458505, 13049142, 12664605, 12302053, 11959109, 11633760, 11324287,
		11029215, 10747856, 10474769, 10210746, 9955140, 9707375, 9466932,
		9233344, 9006190, 8785087, 8569685, 8359666, 8154739, 7954635,
		7759109, 7567932, 7380894, 7197800, 7018468, 6842731, 6670431,
		6501421, 6335564, 6172732, 6012804, 5855667, 5701214, 5549344,
		5399964, 5252984, 5108319, 4965890, 4825620, 4687438, 4551275,
		4417067, 4284753, 4154273, 4025571, 3898595, 3773293, 3649617,
		3527520, 3406959, 3287890, 3170273, 3054069, 2939240, 2825751,
		2713568, 2602657, 2492986, 2384524, 2277244, 2171115, 2066111,
		1962205, 1859372, 1757589, 1656830, 1557073, 1458297, 1360479,
		1263600, 1167640, 1072578, 978398, 885080, 792607, 700962,
		610130, 520093, 430837, 342346, 254606, 167604, 81324,
		-4245, -89118, -173306, -256821, -339677, -421883
	};

	// control that travels with a sample down the pipe
	typedef struct packed {
		logic valid;
		logic gnd;
		logic oor;
	} tag_t;

	// one finished result
	typedef struct packed {
		logic signed [ALT_W-1:0] agl;
		logic signed [ALT_W-1:0] msl;
		logic                    oor;
	} res_t;

endpackage

/* hdl/palt_rom.sv */
module palt_rom (
	input  logic                                clk,
	input  logic [palt_pkg::IDX_W-1:0]          addr_hi,
	input  logic [palt_pkg::IDX_W-1:0]          addr_lo,
	output logic signed [palt_pkg::ALT_W-1:0]   hi_s1,
	output logic signed [palt_pkg::ALT_W-1:0]   lo_s1
);

	localparam int AW = palt_pkg::ALT_W;

	// two registered read ports on the altitude table
	always_ff @(posedge clk) begin
		hi_s1 <= AW'(palt_pkg::ALT_TABLE[addr_hi]);
		lo_s1 <= AW'(palt_pkg::ALT_TABLE[addr_lo]);
	end

endmodule

/* hdl/palt_interp.sv */
module palt_interp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [palt_pkg::PRESS_W-1:0]        press_s0,
	input  palt_pkg::tag_t                      tag_s0,
	output logic signed [palt_pkg::ALT_W-1:0]   alt_s3,
	output palt_pkg::tag_t                      tag_s3
);

	localparam int AW = palt_pkg::ALT_W;
	localparam int PW = palt_pkg::PROD_W;
	localparam int CW = palt_pkg::CLAMP_W;
	localparam int IW = palt_pkg::IDX_W;
	localparam int SH = palt_pkg::STEP_SHIFT;

	logic [CW-1:0]         pc;
	logic                  clamp_oor;
	logic [IW-1:0]         k;
	logic [IW-1:0]         addr_hi;
	palt_pkg::tag_t        tag_c;

	logic signed [AW-1:0]  hi_s1;
	logic signed [AW-1:0]  lo_s1;
	logic [SH-1:0]         f_s1;
	palt_pkg::tag_t        tag_s1;

	logic signed [AW:0]    diff;
	logic [AW-1:0]         diff_pos;

	logic [PW-1:0]         prod_s2;
	logic signed [AW-1:0]  hi_s2;
	palt_pkg::tag_t        tag_s2;

	logic [AW-1:0]         sh;
	logic signed [AW-1:0]  alt_c;

	// clamp to the table window
	always_comb begin
		clamp_oor = 1'b0;
		if (press_s0 < palt_pkg::P_MIN) begin
			pc        = CW'(palt_pkg::P_MIN);
			clamp_oor = 1'b1;
		end else if (press_s0 > palt_pkg::P_MAX) begin
			pc        = CW'(palt_pkg::P_MAX);
			clamp_oor = 1'b1;
		end else begin
			pc = CW'(press_s0);
		end
	end

	// table index and its upper neighbor
	assign k       = pc[CW-1:SH];
	assign addr_hi = k - IW'(1);

	always_comb begin
		tag_c     = tag_s0;
		tag_c.oor = tag_s0.oor | clamp_oor;
	end

	palt_rom u_rom (
		.clk     (clk),
		.addr_hi (addr_hi),
		.addr_lo (k),
		.hi_s1   (hi_s1),
		.lo_s1   (lo_s1)
	);

	// slope times fraction, negative slope floored at zero
	assign diff     = {hi_s1[AW-1], hi_s1} - {lo_s1[AW-1], lo_s1};
	assign diff_pos = diff[AW] ? '0 : diff[AW-1:0];

	// step down from the upper entry
	assign sh    = prod_s2[PW-1:SH];
	assign alt_c = AW'(hi_s2 - sh);

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_c;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		f_s1    <= pc[SH-1:0];
		prod_s2 <= PW'(diff_pos) * PW'(f_s1);
		hi_s2   <= hi_s1;
		alt_s3  <= alt_c;
	end

endmodule

/* hdl/palt_obuf.sv */
module palt_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             wr_valid,
	input  palt_pkg::res_t   wr_res,
	output logic             rd_valid,
	input  logic             rd_ready,
	output palt_pkg::res_t   rd_res,
	output logic             credit_ok
);

	localparam int DEPTH = palt_pkg::OBUF_DEPTH;
	localparam int AW    = palt_pkg::OBUF_AW;
	localparam int CW    = palt_pkg::CNT_W;

	palt_pkg::res_t  mem_q [DEPTH];
	palt_pkg::res_t  rd_res_q;
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW-1:0]   rd_next;
	logic [CW-1:0]   level_q;
	logic [CW-1:0]   credit_q;
	logic            pop;

	assign rd_valid  = (level_q != '0);
	assign pop       = rd_valid && rd_ready;
	assign rd_next   = pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
	assign rd_res    = rd_res_q;
	// one slot reserved per sample in flight
	assign credit_ok = (credit_q < CW'(DEPTH));

	// pointers, fill level and reserved slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
			credit_q <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			level_q  <= level_q + CW'(wr_valid) - CW'(pop);
			credit_q <= credit_q + CW'(take) - CW'(pop);
		end
	end

	// storage, with the next head entry prefetched into a register
	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
		// an entry written now and read next bypasses the array
		if (wr_valid && (wr_ptr_q == rd_next)) begin
			rd_res_q <= wr_res;
		end else begin
			rd_res_q <= mem_q[rd_next];
		end
	end

endmodule

/* hdl/pressure_to_altitude_interp.sv */
// Pressure to altitude. Each pressure sample (Pa) gives one result: altitude
// above sea level and above the ground reference, both in mm, plus a flag when
// either pressure had to be clamped to the table window 1024..106495 Pa. One
// sample is taken every cycle while s_axis_tready is high; a result passes
// through a four-stage pipe (table read, multiply, subtract, output buffer).
// An eight-entry output buffer with slot reservation keeps the input side
// running while the output side stalls; the input also stalls when eight
// samples are outstanding. After reset and after every ground pressure write,
// the input is held while the ground altitude is sent through the same pipe;
// no clearing pass is needed.
module pressure_to_altitude_interp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [palt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // pressure
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [palt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // altitude_msl, altitude_agl
	output logic                                 m_axis_tuser,  // out_of_range
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [palt_pkg::PRESS_W-1:0]         cfg_data
);

	localparam int PW = palt_pkg::PRESS_W;
	localparam int AW = palt_pkg::ALT_W;
	localparam int TW = palt_pkg::OUT_TDATA_W;

	logic [PW-1:0]         ground_q;
	logic                  pending_q;
	logic signed [AW-1:0]  gnd_alt_q;
	logic                  gnd_oor_q;

	logic                  in_xfer;
	logic                  cfg_xfer;
	logic                  credit_ok;
	logic [PW-1:0]         press_s0;
	palt_pkg::tag_t        tag_s0;
	logic signed [AW-1:0]  alt_s3;
	palt_pkg::tag_t        tag_s3;
	logic                  wr_valid;
	palt_pkg::res_t        wr_res;
	palt_pkg::res_t        rd_res;

	assign cfg_ready     = 1'b1;
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign s_axis_tready = credit_ok && !pending_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// ground reference and its recompute request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q  <= PW'(palt_pkg::GROUND_RESET);
			pending_q <= 1'b1;
		end else begin
			pending_q <= cfg_xfer;
			if (cfg_xfer) begin
				ground_q <= cfg_data;
			end
		end
	end

	// issue either the ground reference or the input sample
	always_comb begin
		press_s0     = pending_q ? ground_q : s_axis_tdata[PW-1:0];
		tag_s0.valid = in_xfer || pending_q;
		tag_s0.gnd   = pending_q;
		tag_s0.oor   = 1'b0;
	end

	palt_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.press_s0 (press_s0),
		.tag_s0   (tag_s0),
		.alt_s3   (alt_s3),
		.tag_s3   (tag_s3)
	);

	// capture the ground altitude when it leaves the pipe
	always_ff @(posedge clk) begin
		if (tag_s3.valid && tag_s3.gnd) begin
			gnd_alt_q <= alt_s3;
			gnd_oor_q <= tag_s3.oor;
		end
	end

	// final result
	always_comb begin
		wr_valid   = tag_s3.valid && !tag_s3.gnd;
		wr_res.msl = alt_s3;
		wr_res.agl = AW'(alt_s3 - gnd_alt_q);
		wr_res.oor = tag_s3.oor | gnd_oor_q;
	end

	palt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_xfer),
		.wr_valid  (wr_valid),
		.wr_res    (wr_res),
		.rd_valid  (m_axis_tvalid),
		.rd_ready  (m_axis_tready),
		.rd_res    (rd_res),
		.credit_ok (credit_ok)
	);

	assign m_axis_tdata = TW'({rd_res.agl, rd_res.msl});
	assign m_axis_tuser = rd_res.oor;

endmodule

/* hdl/palt_check.sv */
`include "assert_macros.svh"

module palt_check (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [palt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [palt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input logic                                 m_axis_tuser,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [palt_pkg::PRESS_W-1:0]         cfg_data
);

	localparam int AW     = palt_pkg::ALT_W;
	localparam int OPEN_W = palt_pkg::CNT_W + 1;
	localparam int MSL_HI = palt_pkg::ALT_TABLE[0];
	localparam int MSL_LO = palt_pkg::ALT_TABLE[palt_pkg::TABLE_ENTRIES-1];

	logic [OPEN_W-1:0]     open_q;
	logic                  in_xfer;
	logic                  out_xfer;
	logic                  cfg_xfer;
	logic signed [AW-1:0]  msl;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign msl      = m_axis_tdata[AW-1:0];

	// samples taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + OPEN_W'(in_xfer) - OPEN_W'(out_xfer);
		end
	end

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// a ground write holds the input while the reference is recomputed
	`ASSERT_NEXT(a_cfg_holds_input, clk, arst_n, cfg_xfer, !s_axis_tready)

	// no result without a sample behind it
	`ASSERT_IMPL(a_no_orphan, clk, arst_n, m_axis_tvalid, open_q != '0)

	// clamped altitude stays inside the table span
	`ASSERT_IMPL(a_msl_span, clk, arst_n, m_axis_tvalid, (msl >= MSL_LO) && (msl <= MSL_HI))

endmodule

bind pressure_to_altitude_interp palt_check u_palt_check (.*);
